// ===== src/lir_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
// Holds register indexes, gain constants and the controller/datapath
// command and status structures. No dependencies.
package lir_pkg;

   localparam int CSR_INDEX_BITS = 2;
   localparam int VOL_BITS = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEREO_IN = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MONO_OUT = 2'd3;

   localparam logic [VOL_BITS-1:0] VOL_UNITY = 16'd32768;
   localparam int STEP_RESET_Q16 = 60211;

   typedef struct packed {
      logic load_prime;
      logic load_skip;
      logic load_run;
      logic calc_prod;
      logic calc_sum;
      logic calc_scale;
      logic emit;
   } lir_cmd_type;

   typedef struct packed {
      logic primed;
      logic phase_ge_one;
      logic out_free;
      logic last;
   } lir_status_type;

endpackage

// ===== src/lir_csr.sv =====
// Configuration registers of the resampler with range clamping on write.
// Depends on lir_pkg for register indexes and gain constants.
module lir_csr
   import lir_pkg::*;
#(
   parameter int PHASE_FRAC_BITS = 16,
   parameter int CSR_DATA_BITS = 21
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   input  logic [CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [CSR_DATA_BITS-1:0]     csr_wdata,
   output logic [PHASE_FRAC_BITS+4:0]   step_eff,
   output logic [VOL_BITS-1:0]          vol_eff,
   output logic                         stereo_in,
   output logic                         mono_out
);

   localparam int F = PHASE_FRAC_BITS;
   localparam int PHW = F + 5;
   localparam logic [PHW-1:0] STEP_LO = PHW'(1) << (F - 4);
   localparam logic [PHW-1:0] STEP_HI = PHW'(1) << (F + 4);
   localparam logic [PHW-1:0] STEP_RST = (F >= 16) ?
      PHW'(STEP_RESET_Q16 << (F - 16)) : PHW'(STEP_RESET_Q16 >> (16 - F));

   logic [PHW-1:0]      step_ff, step_in, step_raw;
   logic [VOL_BITS-1:0] vol_ff, vol_in, vol_raw;
   logic                stereo_ff, stereo_in_nx;
   logic                mono_ff, mono_in;

   always_comb begin
      step_raw = csr_wdata[PHW-1:0];
      vol_raw = csr_wdata[VOL_BITS-1:0];
      step_in = step_ff;
      vol_in = vol_ff;
      stereo_in_nx = stereo_ff;
      mono_in = mono_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_PHASE_STEP: begin
               if (step_raw < STEP_LO) begin
                  step_in = STEP_LO;
               end else if (step_raw > STEP_HI) begin
                  step_in = STEP_HI;
               end else begin
                  step_in = step_raw;
               end
            end
            CSR_VOLUME: begin
               vol_in = (vol_raw > VOL_UNITY) ? VOL_UNITY : vol_raw;
            end
            CSR_STEREO_IN: begin
               stereo_in_nx = csr_wdata[0];
            end
            CSR_MONO_OUT: begin
               mono_in = csr_wdata[0];
            end
            default: begin
               step_in = step_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RST;
         vol_ff <= VOL_UNITY;
         stereo_ff <= 1'b1;
         mono_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         vol_ff <= vol_in;
         stereo_ff <= stereo_in_nx;
         mono_ff <= mono_in;
      end
   end

   assign step_eff = step_ff;
   assign vol_eff = vol_ff;
   assign stereo_in = stereo_ff;
   assign mono_out = mono_ff;

endmodule

// ===== src/lir_ctrl.sv =====
// Controller state machine of the resampler: sequences input transfers and
// the four datapath steps of each output frame. Depends on lir_pkg.
module lir_ctrl
   import lir_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  lir_status_type status,
   output lir_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PROD = 3'd1;
   localparam logic [2:0] ST_SUM = 3'd2;
   localparam logic [2:0] ST_SCALE = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       take;

   assign req_stall = (state_ff != ST_IDLE);
   assign take = req_valid && (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               priority if (!status.primed) begin
                  cmd.load_prime = 1'b1;
               end else if (status.phase_ge_one) begin
                  cmd.load_skip = 1'b1;
               end else begin
                  cmd.load_run = 1'b1;
                  state_in = ST_PROD;
               end
            end
         end
         ST_PROD: begin
            cmd.calc_prod = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.calc_sum = 1'b1;
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.calc_scale = 1'b1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = status.last ? ST_IDLE : ST_PROD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/lir_dp.sv =====
// Datapath of the resampler: frame history, phase accumulator, interpolation,
// gain, clamping with rounding, and the result register. Depends on lir_pkg.
module lir_dp
   import lir_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  lir_cmd_type                   cmd,
   output lir_status_type                status,
   input  logic [PHASE_FRAC_BITS+4:0]    step_eff,
   input  logic [VOL_BITS-1:0]           vol_eff,
   input  logic                          stereo_in,
   input  logic                          mono_out,
   input  logic signed [SAMPLE_BITS-1:0] req_in_left,
   input  logic signed [SAMPLE_BITS-1:0] req_in_right,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   output logic                          rsp_run_last
);

   localparam int S = SAMPLE_BITS;
   localparam int F = PHASE_FRAC_BITS;
   localparam int PHW = F + 5;
   localparam int PW = S + F + 2;
   localparam int AW = S + F + 3;
   localparam int MW = AW + VOL_BITS;
   localparam int G0 = F + 15;
   localparam int G1 = F + 16;
   localparam int K0 = G0 + S - 1;
   localparam int K1 = G1 + S - 1;
   localparam logic [PHW-1:0] PH_ONE = PHW'(1) << F;
   localparam logic [MW-1:0] LIM0 = MW'(1) << K0;
   localparam logic [MW-1:0] LIM1 = MW'(1) << K1;
   localparam logic [MW-1:0] LO_MASK0 = (MW'(1) << G0) - MW'(1);
   localparam logic [MW-1:0] LO_MASK1 = (MW'(1) << G1) - MW'(1);
   localparam logic [MW-1:0] RND0 = MW'(1) << (K0 - 1);
   localparam logic [MW-1:0] RND1 = MW'(1) << (K1 - 1);

   function automatic logic [S-1:0] round_mag(input logic [MW-1:0] m, input logic half);
      logic [MW-1:0] lim;
      logic [MW-1:0] mc;
      logic [MW-1:0] hi;
      logic [MW-1:0] lo;
      logic [MW-1:0] y;
      logic [S:0]    r;
      lim = half ? LIM1 : LIM0;
      mc = (m > lim) ? lim : m;
      hi = half ? (mc >> G1) : (mc >> G0);
      lo = mc & (half ? LO_MASK1 : LO_MASK0);
      y = (lo << (S - 1)) + (half ? RND1 : RND0);
      r = hi[S:0];
      if (y < mc) begin
         r = r - (S+1)'(1);
      end else if ((y - mc) >= lim) begin
         r = r + (S+1)'(1);
      end
      return r[S-1:0];
   endfunction

   logic signed [S-1:0]  prev_l_ff, prev_r_ff, cur_l_ff, cur_r_ff;
   logic signed [S-1:0]  in_r_sel;
   logic [PHW-1:0]       phase_ff, phase_in, phase_adv;
   logic                 primed_ff;
   logic signed [PW-1:0] prod_l_ff, prod_r_ff, prod_l_in, prod_r_in;
   logic signed [S:0]    diff_l, diff_r;
   logic signed [F:0]    frac;
   logic signed [AW-1:0] base_l, base_r, a_l, a_r, mix_l;
   logic [AW-1:0]        mag_l_ff, mag_r_ff, mag_l_in, mag_r_in;
   logic                 neg_l_ff, neg_r_ff;
   logic [MW-1:0]        m_l_ff, m_r_ff;
   logic [S-1:0]         r_l, r_r;
   logic signed [S-1:0]  out_l_in, out_r_in;
   logic                 last;
   logic                 rsp_valid_ff;
   logic signed [S-1:0]  rsp_left_ff, rsp_right_ff;
   logic                 rsp_last_ff;

   assign in_r_sel = stereo_in ? req_in_right : req_in_left;

   assign phase_adv = phase_ff + step_eff;
   assign last = (phase_adv >= PH_ONE);

   always_comb begin
      diff_l = {cur_l_ff[S-1], cur_l_ff} - {prev_l_ff[S-1], prev_l_ff};
      diff_r = {cur_r_ff[S-1], cur_r_ff} - {prev_r_ff[S-1], prev_r_ff};
      frac = {1'b0, phase_ff[F-1:0]};
      prod_l_in = PW'(diff_l) * PW'(frac);
      prod_r_in = PW'(diff_r) * PW'(frac);
   end

   always_comb begin
      base_l = AW'(signed'({prev_l_ff, {F{1'b0}}}));
      base_r = AW'(signed'({prev_r_ff, {F{1'b0}}}));
      a_l = base_l + AW'(prod_l_ff);
      a_r = base_r + AW'(prod_r_ff);
      mix_l = mono_out ? (a_l + a_r) : a_l;
      mag_l_in = mix_l[AW-1] ? AW'(-mix_l) : AW'(mix_l);
      mag_r_in = a_r[AW-1] ? AW'(-a_r) : AW'(a_r);
   end

   always_comb begin
      r_l = round_mag(m_l_ff, mono_out);
      r_r = round_mag(m_r_ff, 1'b0);
      out_l_in = neg_l_ff ? -signed'(r_l) : signed'(r_l);
      out_r_in = mono_out ? '0 : (neg_r_ff ? -signed'(r_r) : signed'(r_r));
   end

   always_comb begin
      phase_in = phase_ff;
      if (cmd.load_prime) begin
         phase_in = '0;
      end else if (cmd.load_skip) begin
         phase_in = phase_ff - PH_ONE;
      end else if (cmd.emit) begin
         phase_in = last ? (phase_adv - PH_ONE) : phase_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff <= 1'b0;
         phase_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         if (cmd.load_prime) begin
            primed_ff <= 1'b1;
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_prime || cmd.load_skip) begin
         prev_l_ff <= req_in_left;
         prev_r_ff <= in_r_sel;
      end else if (cmd.emit && last) begin
         prev_l_ff <= cur_l_ff;
         prev_r_ff <= cur_r_ff;
      end
      if (cmd.load_run) begin
         cur_l_ff <= req_in_left;
         cur_r_ff <= in_r_sel;
      end
      if (cmd.calc_prod) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
      end
      if (cmd.calc_sum) begin
         mag_l_ff <= mag_l_in;
         mag_r_ff <= mag_r_in;
         neg_l_ff <= mix_l[AW-1];
         neg_r_ff <= a_r[AW-1];
      end
      if (cmd.calc_scale) begin
         m_l_ff <= MW'(mag_l_ff) * MW'(vol_eff);
         m_r_ff <= MW'(mag_r_ff) * MW'(vol_eff);
      end
      if (cmd.emit) begin
         rsp_left_ff <= out_l_in;
         rsp_right_ff <= out_r_in;
         rsp_last_ff <= last;
      end
   end

   assign status.primed = primed_ff;
   assign status.phase_ge_one = (phase_ff >= PH_ONE);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;
   assign status.last = last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_left = rsp_left_ff;
   assign rsp_out_right = rsp_right_ff;
   assign rsp_run_last = rsp_last_ff;

endmodule

// ===== src/linear_interp_audio_resampler_top.sv =====
// The first input frame after reset only primes the history and gives no
// output. Each later frame is transferred and then produces zero or more
// output frames (at most 16), each passing in turn through the shared
// product, sum, gain and rounding steps; the input side stays stalled
// while the output frames of an input are produced, also while the result
// register is held by rsp_stall. The last output frame of an input is
// flagged by rsp_run_last, and the next input is taken while that output
// still waits. Configuration writes are always ready and take effect at
// once; they are to be made only while the block is idle.
//
// Top level of the linear interpolation resampler.
// Depends on lir_pkg, lir_csr, lir_ctrl and lir_dp.
module linear_interp_audio_resampler_top
   import lir_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int PHASE_FRAC_BITS = 16,
   localparam int CSR_DATA_BITS = (PHASE_FRAC_BITS + 5 > 16) ? PHASE_FRAC_BITS + 5 : 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_BITS-1:0] req_in_left,
   input  logic signed [SAMPLE_BITS-1:0] req_in_right,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   output logic                          rsp_run_last,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [CSR_DATA_BITS-1:0]      csr_wdata
);

   logic [PHASE_FRAC_BITS+4:0] step_eff;
   logic [VOL_BITS-1:0]        vol_eff;
   logic                       stereo_in;
   logic                       mono_out;
   lir_cmd_type                cmd;
   lir_status_type             status;

   assign csr_ready = 1'b1;

   lir_csr #(
      .PHASE_FRAC_BITS(PHASE_FRAC_BITS),
      .CSR_DATA_BITS(CSR_DATA_BITS)
   ) u_csr (
      .clock(clock),
      .reset(reset),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .step_eff(step_eff),
      .vol_eff(vol_eff),
      .stereo_in(stereo_in),
      .mono_out(mono_out)
   );

   lir_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status(status),
      .cmd(cmd)
   );

   lir_dp #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
   ) u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .step_eff(step_eff),
      .vol_eff(vol_eff),
      .stereo_in(stereo_in),
      .mono_out(mono_out),
      .req_in_left(req_in_left),
      .req_in_right(req_in_right),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_out_left(rsp_out_left),
      .rsp_out_right(rsp_out_right),
      .rsp_run_last(rsp_run_last)
   );

endmodule

// ===== dv/linear_interp_audio_resampler_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for linear_interp_audio_resampler_top: feeds source frames and
// register writes, predicts every interpolated output frame and compares each transfer.
// Depends on lir_pkg and the resampler RTL; needs no files or arguments.
module linear_interp_audio_resampler_top_test;
   import lir_pkg::*;

   localparam int SAMPLE_BITS = 16;
   localparam int PHASE_FRAC_BITS = 16;
   localparam int CSR_DATA_BITS = PHASE_FRAC_BITS + 5;
   localparam int unsigned FRAME_ONE = 1 << PHASE_FRAC_BITS;
   localparam int unsigned STEP_MIN = FRAME_ONE >> 4;
   localparam int unsigned STEP_MAX = FRAME_ONE << 4;
   localparam int unsigned STEP_MASK = (1 << CSR_DATA_BITS) - 1;
   localparam int MAX_RUN = 16;
   localparam int GAIN_SHIFT = PHASE_FRAC_BITS + 15 + SAMPLE_BITS - 1;
   localparam longint FULL_SCALE = (64'd1 << (SAMPLE_BITS - 1)) - 1;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int MAX_REPORTS = 40;
   localparam int NUM_PHASES = 7;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct {
      sample_type left;
      sample_type right;
      logic       run_last;
   } out_frame_type;

   typedef struct {
      bit                        is_write;
      logic [CSR_INDEX_BITS-1:0] index;
      int unsigned               value;
      sample_type                left;
      sample_type                right;
      bit                        pinned;
      sample_type                pin_left;
      sample_type                pin_right;
   } plan_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   sample_type                req_in_left = '0;
   sample_type                req_in_right = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   sample_type                rsp_out_left;
   sample_type                rsp_out_right;
   logic                      rsp_run_last;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_PHASE_STEP;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   logic hold_request = 1'b0;
   logic stall_enable = 1'b0;

   // Shadow of the registers and of the interpolation history.
   int unsigned cfg_step = STEP_RESET_Q16;
   int unsigned cfg_volume = VOL_UNITY;
   bit          cfg_stereo = 1'b1;
   bit          cfg_mono = 1'b0;
   int          hist_left = 0;
   int          hist_right = 0;
   int unsigned phase_pos = 0;
   bit          primed = 1'b0;

   out_frame_type expected_frames[$];
   plan_row_type  plan[$];
   int            mismatches = 0;
   int            frames_sent = 0;
   int            frames_checked = 0;
   int            frames_predicted = 0;
   int            settings_used = 1;

   linear_interp_audio_resampler_top u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_left   (req_in_left),
      .req_in_right  (req_in_right),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_left  (rsp_out_left),
      .rsp_out_right (rsp_out_right),
      .rsp_run_last  (rsp_run_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
         $display("%0t: %s", $time, what);
      end
   endtask

   // Applies gain, clamps to full scale and rounds half away from zero.
   function automatic sample_type gain_round(longint acc, bit mix);
      int                shift;
      longint unsigned   gain;
      longint unsigned   mag;
      longint unsigned   prod;
      longint unsigned   code;
      shift = GAIN_SHIFT + (mix ? 1 : 0);
      gain = (cfg_volume > VOL_UNITY) ? VOL_UNITY : cfg_volume;
      mag = (acc < 0) ? -acc : acc;
      prod = mag * gain;
      if (prod > (64'd1 << shift)) begin
         prod = 64'd1 << shift;
      end
      code = (prod * FULL_SCALE + (64'd1 << (shift - 1))) >> shift;
      return (acc < 0) ? -sample_type'(code) : sample_type'(code);
   endfunction

   function automatic void apply_setting(logic [CSR_INDEX_BITS-1:0] index, int unsigned value);
      case (index)
         CSR_PHASE_STEP: cfg_step = value & STEP_MASK;
         CSR_VOLUME:     cfg_volume = value & 32'hFFFF;
         CSR_STEREO_IN:  cfg_stereo = value[0];
         CSR_MONO_OUT:   cfg_mono = value[0];
         default:        ;
      endcase
   endfunction

   // Queues the output frames that one source frame produces. A pinned frame
   // has its first output written out by hand instead of computed.
   function automatic void resample_frame(sample_type in_l, sample_type in_r, bit pinned,
                                          sample_type pin_l, sample_type pin_r);
      int            cur_l;
      int            cur_r;
      int            n;
      int unsigned   step_eff;
      longint        acc_l;
      longint        acc_r;
      out_frame_type f;
      cur_l = in_l;
      cur_r = cfg_stereo ? int'(in_r) : cur_l;
      step_eff = (cfg_step < STEP_MIN) ? STEP_MIN : ((cfg_step > STEP_MAX) ? STEP_MAX : cfg_step);
      n = 0;
      if (!primed) begin
         primed = 1'b1;
         phase_pos = 0;
      end else begin
         while (phase_pos < FRAME_ONE && n < MAX_RUN) begin
            acc_l = longint'(hist_left) * longint'(FRAME_ONE)
                  + longint'(cur_l - hist_left) * longint'(phase_pos);
            acc_r = longint'(hist_right) * longint'(FRAME_ONE)
                  + longint'(cur_r - hist_right) * longint'(phase_pos);
            if (cfg_mono) begin
               f.left = gain_round(acc_l + acc_r, 1'b1);
               f.right = '0;
            end else begin
               f.left = gain_round(acc_l, 1'b0);
               f.right = gain_round(acc_r, 1'b0);
            end
            if (pinned && n == 0) begin
               f.left = pin_l;
               f.right = pin_r;
            end
            phase_pos = phase_pos + step_eff;
            n++;
            f.run_last = (phase_pos >= FRAME_ONE) || (n == MAX_RUN);
            expected_frames.push_back(f);
         end
         phase_pos = (phase_pos - FRAME_ONE) & STEP_MASK;
      end
      hist_left = cur_l;
      hist_right = cur_r;
      frames_predicted += n;
   endfunction

   function automatic void plan_write(logic [CSR_INDEX_BITS-1:0] index, int unsigned value);
      plan_row_type row;
      row = '{1'b1, index, value, '0, '0, 1'b0, '0, '0};
      plan.push_back(row);
   endfunction

   function automatic void plan_frame(sample_type l, sample_type r, bit pinned,
                                      sample_type pl, sample_type pr);
      plan_row_type row;
      row = '{1'b0, CSR_PHASE_STEP, 0, l, r, pinned, pl, pr};
      plan.push_back(row);
   endfunction

   function automatic sample_type pick_extreme();
      case ($urandom_range(0, 5))
         0:       return -16'sd32768;
         1:       return -16'sd32767;
         2:       return -16'sd1;
         3:       return 16'sd0;
         4:       return 16'sd1;
         default: return 16'sd32767;
      endcase
   endfunction

   function automatic sample_type drift(sample_type base);
      int v;
      v = int'(base) + int'($urandom_range(0, 4000)) - 2000;
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32768) begin
         v = -32768;
      end
      return sample_type'(v);
   endfunction

   // Each task below is entered and left right after a rising clock edge.
   task automatic send_frame(sample_type in_l, sample_type in_r, bit pinned, sample_type pin_l,
                             sample_type pin_r);
      req_valid <= 1'b1;
      req_in_left <= in_l;
      req_in_right <= in_r;
      do @(posedge clock); while (req_stall);
      resample_frame(in_l, in_r, pinned, pin_l, pin_r);
      frames_sent++;
   endtask

   task automatic idle_sender(bit allow);
      int pick;
      int gap;
      pick = $urandom_range(0, 99);
      if (!allow || pick < 55) begin
         gap = 0;
      end else if (pick < 90) begin
         gap = $urandom_range(1, 3);
      end else begin
         gap = $urandom_range(8, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // A frame that gives no output can still be in flight after the last
   // expected transfer, so a few more cycles pass before going on.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_setting(logic [CSR_INDEX_BITS-1:0] index, int unsigned value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= CSR_DATA_BITS'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      apply_setting(index, value);
   endtask

   always @(posedge clock) begin : check_outputs
      out_frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         frames_checked++;
         if (expected_frames.size() == 0) begin
            report_mismatch($sformatf("unexpected output frame (%0d, %0d, last %0b)",
                                      rsp_out_left, rsp_out_right, rsp_run_last));
         end else begin
            want = expected_frames.pop_front();
            if (rsp_out_left !== want.left || rsp_out_right !== want.right
                || rsp_run_last !== want.run_last) begin
               report_mismatch($sformatf(
                  "output frame %0d: got (%0d, %0d, last %0b), expected (%0d, %0d, last %0b)",
                  frames_checked, rsp_out_left, rsp_out_right, rsp_run_last,
                  want.left, want.right, want.run_last));
            end
         end
      end
   end

   initial begin : result_side
      int len;
      bit held;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_enable && $urandom_range(0, 3) == 0) begin
            len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (len) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin : stimulus
      int          p;
      int          k;
      int          items;
      bit          quiet;
      int unsigned st;
      int unsigned vol;
      int unsigned ster;
      int unsigned mon;
      sample_type  l;
      sample_type  r;

      // Reset settings first: priming, full-scale extremes, then gain, channel
      // modes and step clamping.
      plan_frame(16'sd32767, -16'sd32768, 1'b0, '0, '0);
      plan_frame(16'sd32767, -16'sd32768, 1'b1, 16'sd32766, -16'sd32767);
      plan_frame(-16'sd32768, 16'sd32767, 1'b0, '0, '0);
      plan_frame(16'sd0, 16'sd0, 1'b0, '0, '0);
      plan_frame(-16'sd1, 16'sd1, 1'b0, '0, '0);
      plan_write(CSR_VOLUME, 65535);
      plan_frame(16'sd32767, 16'sd32767, 1'b0, '0, '0);
      plan_frame(-16'sd32768, -16'sd32768, 1'b0, '0, '0);
      plan_write(CSR_VOLUME, 0);
      plan_frame(16'sd12345, -16'sd12345, 1'b1, 16'sd0, 16'sd0);
      plan_write(CSR_VOLUME, VOL_UNITY);
      plan_write(CSR_STEREO_IN, 0);
      plan_frame(-16'sd32768, 16'sd4660, 1'b0, '0, '0);
      plan_frame(-16'sd32768, 16'sd1, 1'b1, -16'sd32767, -16'sd32767);
      plan_write(CSR_MONO_OUT, 1);
      plan_frame(-16'sd32768, 16'sd77, 1'b1, -16'sd32767, 16'sd0);
      plan_frame(16'sd32767, 16'sd0, 1'b0, '0, '0);
      plan_write(CSR_PHASE_STEP, 0);
      plan_frame(16'sd1000, -16'sd1000, 1'b0, '0, '0);
      plan_frame(-16'sd1000, 16'sd1000, 1'b0, '0, '0);
      plan_write(CSR_STEREO_IN, 1);
      plan_write(CSR_MONO_OUT, 0);
      plan_write(CSR_PHASE_STEP, 2097151);
      plan_frame(16'sd100, 16'sd200, 1'b0, '0, '0);
      plan_frame(16'sd300, -16'sd400, 1'b0, '0, '0);
      plan_frame(-16'sd5, 16'sd6, 1'b0, '0, '0);
      plan_frame(16'sd7, -16'sd8, 1'b0, '0, '0);
      plan_frame(16'sd9, 16'sd10, 1'b0, '0, '0);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      stall_enable <= 1'b1;

      foreach (plan[i]) begin
         if (plan[i].is_write) begin
            write_setting(plan[i].index, plan[i].value);
            settings_used++;
         end else begin
            send_frame(plan[i].left, plan[i].right, plan[i].pinned, plan[i].pin_left,
                       plan[i].pin_right);
            idle_sender(1'b1);
         end
      end

      for (p = 0; p < NUM_PHASES; p++) begin
         case (p)
            0: begin st = STEP_MIN; vol = VOL_UNITY; ster = 1; mon = 0; end
            1: begin st = 0; vol = 65535; ster = 0; mon = 1; end
            2: begin st = 2097151; vol = 21845; ster = 1; mon = 1; end
            3: begin st = STEP_MAX; vol = 32767; ster = 0; mon = 0; end
            4: begin st = FRAME_ONE; vol = VOL_UNITY; ster = 1; mon = 0; end
            default: begin
               st = $urandom_range(STEP_MIN, 2 * FRAME_ONE);
               vol = $urandom_range(0, 40000);
               ster = $urandom_range(0, 1);
               mon = $urandom_range(0, 1);
            end
         endcase
         // Bits above each register's width are junk that the block drops.
         write_setting(CSR_PHASE_STEP, st);
         write_setting(CSR_VOLUME, vol | ($urandom_range(0, 31) << 16));
         write_setting(CSR_STEREO_IN, ster | ($urandom_range(0, 1023) << 1));
         write_setting(CSR_MONO_OUT, mon | ($urandom_range(0, 1023) << 1));
         settings_used++;
         quiet = (p == 4);
         stall_enable <= !quiet;
         if (p == 0) begin
            hold_request <= 1'b1;
         end
         items = 0;
         while (items < 30) begin
            if (p == 1 && items == 15) begin
               wait_drained();
            end
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: begin
                  l = sample_type'($urandom);
                  r = sample_type'($urandom);
               end
               5, 6: begin
                  l = pick_extreme();
                  r = pick_extreme();
               end
               default: begin
                  l = drift(req_in_left);
                  r = drift(req_in_right);
               end
            endcase
            send_frame(l, r, 1'b0, '0, '0);
            items++;
            idle_sender(!quiet);
         end
      end

      req_valid <= 1'b0;
      for (k = 0; k < 50000 && expected_frames.size() != 0; k++) @(posedge clock);
      repeat (4 * SETTLE_CYCLES) @(posedge clock);
      if (expected_frames.size() != 0) begin
         report_mismatch($sformatf("%0d expected output frames never arrived",
                                   expected_frames.size()));
      end
      $display("Sent %0d source frames, checked %0d of %0d predicted output frames",
               frames_sent, frames_checked, frames_predicted);
      $display("under %0d register settings, covering step and gain clamping, mono %s",
               settings_used, "source and mono mix, and a long output hold.");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("Run exceeded its time budget.");
      $display("Test completed with failures");
      $finish;
   end

endmodule
